>>> sv/count_pair_stream_compressor_top_assert.svh
// assertion macros for the count pair stream compressor
`ifndef COUNT_PAIR_STREAM_COMPRESSOR_TOP_ASSERT_SVH
`define COUNT_PAIR_STREAM_COMPRESSOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define CPSC_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define CPSC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`else

`define CPSC_ASSERT_NOW(label, cond, prop, msg)
`define CPSC_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

>>> sv/cpsc_pkg.sv
// shared types, constants and helpers of the count pair stream compressor
package cpsc_pkg;

   localparam int RunWidth = 14;
   localparam int RunLimit = 1 << RunWidth;

   // a pending run is flushed once it reaches this length
   localparam logic [RunWidth-1:0] RunMax = RunWidth'(RunLimit - 2);

   localparam logic [31:0] SmallLimit  = 32'd7;
   localparam logic [31:0] MediumLimit = 32'd127;
   localparam logic [31:0] WideLimit   = 32'h7FFF_FFFF;
   // values at or above this need two shift steps to fit below the wide limit
   localparam logic [31:0] WideLimit2  = 32'hFFFF_FFFE;

   localparam logic [3:0] BytesRun    = 4'd2;
   localparam logic [3:0] BytesSmall  = 4'd1;
   localparam logic [3:0] BytesMedium = 4'd2;
   localparam logic [3:0] BytesWide   = 4'd8;

   // record type held in the low two bits of each record
   typedef enum logic [1:0] {
      REC_RUN    = 2'd0,
      REC_SMALL  = 2'd1,
      REC_MEDIUM = 2'd2,
      REC_WIDE   = 2'd3
   } rec_kind_type;

   typedef struct packed {
      logic [31:0] methylated_count;
      logic [31:0] unmethylated_count;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] record;
      logic [3:0]  record_bytes;
      logic        last_for_item;
      logic        end_of_stream;
   } rsp_type;

   // everything one site produces, up to two records
   typedef struct packed {
      logic [1:0]          count;
      rsp_type             first;
      rsp_type             second;
      logic [RunWidth-1:0] next_run;
   } enc_type;

   // zero run record of a given length
   function automatic rsp_type run_record(input logic [RunWidth-1:0] len,
                                          input logic last_item,
                                          input logic eos);
      rsp_type r;
      r.record        = {{(64 - RunWidth - 2){1'b0}}, len, REC_RUN};
      r.record_bytes  = BytesRun;
      r.last_for_item = last_item;
      r.end_of_stream = eos;
      return r;
   endfunction

endpackage

>>> sv/cpsc_pair_fmt.sv
// formats one nonzero count pair into a small, medium or wide record
module cpsc_pair_fmt
   import cpsc_pkg::*;
(
   input  logic [31:0] meth,
   input  logic [31:0] unmeth,
   output logic [63:0] record,
   output logic [3:0]  record_bytes
);

   logic [31:0] larger;
   logic [1:0]  shift;
   logic [31:0] meth_sh;
   logic [31:0] unmeth_sh;

   // common right shift so that both counts fall below the wide limit
   assign larger = (meth >= unmeth) ? meth : unmeth;

   always_comb begin
      if (larger >= WideLimit2) begin
         shift = 2'd2;
      end else if (larger >= WideLimit) begin
         shift = 2'd1;
      end else begin
         shift = 2'd0;
      end
   end

   assign meth_sh   = meth >> shift;
   assign unmeth_sh = unmeth >> shift;

   // pick the shortest form whose limit both counts fall below
   always_comb begin
      if (meth < SmallLimit && unmeth < SmallLimit) begin
         record       = {56'd0, meth[2:0], unmeth[2:0], REC_SMALL};
         record_bytes = BytesSmall;
      end else if (meth < MediumLimit && unmeth < MediumLimit) begin
         record       = {48'd0, meth[6:0], unmeth[6:0], REC_MEDIUM};
         record_bytes = BytesMedium;
      end else begin
         record       = {meth_sh[30:0], unmeth_sh[30:0], REC_WIDE};
         record_bytes = BytesWide;
      end
   end

endmodule

>>> sv/cpsc_encode.sv
// per-site encoding: zero run bookkeeping and selection of up to two records
module cpsc_encode
   import cpsc_pkg::*;
(
   input  req_type             item,
   input  logic [RunWidth-1:0] run,
   output enc_type             enc
);

   logic [63:0]         pair_rec;
   logic [3:0]          pair_bytes;
   rsp_type             pair;
   logic                nonzero;
   logic                at_limit;
   logic [RunWidth-1:0] run_inc;

   cpsc_pair_fmt u_pair_fmt (
      .meth         (item.methylated_count),
      .unmeth       (item.unmethylated_count),
      .record       (pair_rec),
      .record_bytes (pair_bytes)
   );

   // a pair record always closes its item
   always_comb begin
      pair.record        = pair_rec;
      pair.record_bytes  = pair_bytes;
      pair.last_for_item = 1'b1;
      pair.end_of_stream = item.is_last;
   end

   assign nonzero  = (|item.methylated_count) || (|item.unmethylated_count);
   assign at_limit = run >= RunMax;
   assign run_inc  = run + RunWidth'(1);

   // record selection and next run length
   always_comb begin
      enc.count    = 2'd0;
      enc.first    = pair;
      enc.second   = pair;
      enc.next_run = run_inc;
      if (nonzero) begin
         // flush the pending run ahead of the pair
         enc.next_run = '0;
         if (run != '0) begin
            enc.count  = 2'd2;
            enc.first  = run_record(run, 1'b0, 1'b0);
            enc.second = pair;
         end else begin
            enc.count = 2'd1;
            enc.first = pair;
         end
      end else if (at_limit) begin
         // full run goes out; this site opens a run of one, sent at once if last
         if (item.is_last) begin
            enc.count    = 2'd2;
            enc.first    = run_record(run, 1'b0, 1'b0);
            enc.second   = run_record(RunWidth'(1), 1'b1, 1'b1);
            enc.next_run = '0;
         end else begin
            enc.count    = 2'd1;
            enc.first    = run_record(run, 1'b1, 1'b0);
            enc.next_run = RunWidth'(1);
         end
      end else if (item.is_last) begin
         // end of stream flushes the grown run
         enc.count    = 2'd1;
         enc.first    = run_record(run_inc, 1'b1, 1'b1);
         enc.next_run = '0;
      end
   end

endmodule

>>> sv/count_pair_stream_compressor_top.sv
// top level of the count pair stream compressor: input register, encoder, result register
//
//  channel | direction | payload  | handshake
//  req_    | in        | req_type | req_valid / req_stall
//  rsp_    | out       | rsp_type | rsp_valid / rsp_stall
//
// one site per cycle unless rsp_ stalls; a two-record site holds the input register for both
// a site's records reach rsp_ through the input register and then the result register
// the run counter is updated as a site leaves the input register
// reset clears valid flags, the record phase and the pending run length
// a stalled result register frees as soon as its record transfers, so the next record loads
`include "count_pair_stream_compressor_top_assert.svh"

module count_pair_stream_compressor_top
   import cpsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                in_valid_ff, in_valid_in;
   req_type             in_ff;
   logic                phase_ff, phase_in;
   logic [RunWidth-1:0] run_ff, run_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff;

   enc_type             enc;
   rsp_type             cur_rec;
   logic                out_free;
   logic                load_out;
   logic                item_done;
   logic                req_xfer;

   cpsc_encode u_encode (
      .item (in_ff),
      .run  (run_ff),
      .enc  (enc)
   );

   // result register slot and item completion
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign load_out  = in_valid_ff && (enc.count != 2'd0) && out_free;
   assign cur_rec   = phase_ff ? enc.second : enc.first;
   assign item_done = in_valid_ff &&
                      ((enc.count == 2'd0) ||
                       (load_out && (phase_ff || enc.count == 2'd1)));

   assign req_stall = in_valid_ff && !item_done;
   assign req_xfer  = req_valid && !req_stall;

   // next values of the control registers
   always_comb begin
      in_valid_in  = req_xfer || (in_valid_ff && !item_done);
      phase_in     = phase_ff;
      run_in       = run_ff;
      out_valid_in = out_valid_ff;
      if (item_done) begin
         phase_in = 1'b0;
         run_in   = enc.next_run;
      end else if (load_out) begin
         phase_in = 1'b1;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= req_data;
      end
      if (load_out) begin
         out_ff <= cur_rec;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // pending run never passes the flush length
   `CPSC_ASSERT_NOW(a_run_bound, 1'b1, run_ff <= RunMax, "pending run above flush length")
   // second record phase only exists with a held site
   `CPSC_ASSERT_NOW(a_phase_held, phase_ff, in_valid_ff, "record phase without a held site")
   // first of two records moves into the second phase
   `CPSC_ASSERT_NEXT(a_phase_enter, load_out && !phase_ff && enc.count == 2'd2, phase_ff,
                     "second record phase not entered")
   // second record closes the site
   `CPSC_ASSERT_NEXT(a_phase_leave, load_out && phase_ff, !phase_ff,
                     "record phase not left after second record")

endmodule
